### src/pc_pkg.sv
// Shared types and constants for the path canonicalizer.
package pc_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_BASE  = 2'd1,
      MODE_REL   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // What the open component looks like so far
   typedef enum logic [1:0] {
      DOT_EMPTY = 2'd0,
      DOT_ONE   = 2'd1,
      DOT_TWO   = 2'd2,
      DOT_NAME  = 2'd3
   } dot_type;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

endpackage

### src/pc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/path_canonicalizer.sv
// Top level of the path canonicalizer: command channel, byte stores, result register.
//
// Usage: a query opens with a start item (req_mode 0), then base path bytes
// (mode 1) and relative path bytes (mode 2), one byte per transfer, with
// req_part_end marking the last byte of each part. Read items (mode 3) then
// return the canonical path one byte per transfer. Without any relative byte
// the raw base path comes back as it was given.
// An item transfers at a rising edge with start high and busy low. busy is
// always low: one item is taken every cycle, back to back.
// Only read items answer. Their result appears on the rsp_ ports for exactly
// one cycle, the cycle right after the transfer, marked by rsp_valid; the
// delay comes from the registered read of the byte stores. The receiver
// cannot stall, so results are never held.
// Store or depth overflow sets a sticky flag that every later read reports
// until the next start item; further path bytes of that query are dropped.
// Reset (synchronous, active high) clears all lengths, positions, query flags
// and rsp_valid; the byte stores and the component stack keep their contents,
// which are never read before being written in the current query.
module path_canonicalizer
   import pc_pkg::*;
#(
   parameter int PATH_BYTES = 256,
   parameter int MAX_DEPTH  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_ch,
   input  logic       req_part_end,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   output logic       rsp_out_empty,
   output logic       rsp_out_overflow
);

   localparam int LW       = $clog2(PATH_BYTES + 1);
   localparam int DW       = $clog2(MAX_DEPTH + 1);
   localparam int RAW_AW   = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;
   localparam int CB_DEPTH = (PATH_BYTES + 1) / 2;
   localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
   localparam int SAW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // Query state
   logic [LW-1:0] canon_len_ff,  canon_len_in;
   logic [LW-1:0] raw_len_ff,    raw_len_in;
   logic [LW-1:0] comp_begin_ff, comp_begin_in;
   logic [LW-1:0] read_pos_ff,   read_pos_in;
   logic [LW-1:0] top_ff,        top_in;
   logic [DW-1:0] depth_ff,      depth_in;
   dot_type       dot_ff,        dot_in;
   logic          rel_seen_ff,   rel_seen_in;
   logic          ovf_ff,        ovf_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_empty_ff, rsp_empty_in;
   logic rsp_last_ff,  rsp_last_in;
   logic rsp_ovf_ff,   rsp_ovf_in;
   logic rsp_slash_ff, rsp_slash_in;
   logic rsp_canon_ff, rsp_canon_in;
   logic rsp_bank_ff,  rsp_bank_in;

   // Decode
   logic     accept;
   mode_type mode;
   logic     is_base, is_rel, is_read, is_start;
   logic     take, drop, ok;
   logic     is_slash, at_begin, canon_over, raw_full, close;
   logic [1:0]    need;
   logic [LW-1:0] len_a;
   dot_type       cls_a;
   logic          push;
   logic [LW-1:0] under;
   logic [LW-1:0] rd_len;
   logic          rd_hit;

   // Store ports
   logic              canon_wr, canon_new;
   logic [LW-1:0]     pos0, pos1;
   logic [7:0]        byte0;
   logic              even_we, odd_we;
   logic [CB_AW-1:0]  even_waddr, odd_waddr, canon_raddr;
   logic [7:0]        even_wdata, odd_wdata, even_rdata, odd_rdata;
   logic [7:0]        raw_rdata;
   logic [SAW-1:0]    stack_raddr;
   logic [DW-1:0]     depth_less2;

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign mode     = mode_type'(req_mode);
   assign is_start = accept && (mode == MODE_START);
   assign is_base  = accept && (mode == MODE_BASE);
   assign is_rel   = accept && (mode == MODE_REL);
   assign is_read  = accept && (mode == MODE_READ);

   // Room check for a path byte
   assign is_slash   = (req_ch == CHAR_SLASH);
   assign at_begin   = (canon_len_ff == comp_begin_ff);
   assign need       = is_slash ? 2'd0 : (at_begin ? 2'd2 : 2'd1);
   assign canon_over = ({1'b0, canon_len_ff} + (LW + 1)'(need)) > (LW + 1)'(PATH_BYTES);
   assign raw_full   = (raw_len_ff >= LW'(PATH_BYTES));
   assign take       = (is_base || is_rel) && !ovf_ff;
   assign drop       = take && ((is_base && raw_full) || canon_over);
   assign ok         = take && !drop;
   assign close      = ok && (is_slash || req_part_end);

   // Next state: append, close, read, start
   always_comb begin
      len_a         = canon_len_ff;
      cls_a         = dot_ff;
      canon_len_in  = canon_len_ff;
      comp_begin_in = comp_begin_ff;
      raw_len_in    = raw_len_ff;
      read_pos_in   = read_pos_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      rel_seen_in   = rel_seen_ff | is_rel;
      ovf_in        = ovf_ff | drop;
      push          = 1'b0;

      if (ok && is_base) begin
         raw_len_in = raw_len_ff + LW'(1);
      end

      // Append a name byte to the open component
      if (ok && !is_slash) begin
         len_a = canon_len_ff + LW'(need);
         unique case (dot_ff)
            DOT_EMPTY: cls_a = (req_ch == CHAR_DOT) ? DOT_ONE : DOT_NAME;
            DOT_ONE:   cls_a = (req_ch == CHAR_DOT) ? DOT_TWO : DOT_NAME;
            DOT_TWO,
            DOT_NAME:  cls_a = DOT_NAME;
         endcase
      end
      canon_len_in = len_a;
      dot_in       = cls_a;

      // Close the component: drop, pop, overflow or push
      if (close) begin
         dot_in = DOT_EMPTY;
         priority if (len_a == comp_begin_ff || cls_a == DOT_ONE) begin
            canon_len_in = comp_begin_ff;
         end else if (cls_a == DOT_TWO) begin
            if (depth_ff != '0) begin
               depth_in     = depth_ff - DW'(1);
               canon_len_in = top_ff;
               top_in       = under;
            end else begin
               canon_len_in = comp_begin_ff;
            end
         end else if (depth_ff >= DW'(MAX_DEPTH)) begin
            ovf_in       = 1'b1;
            canon_len_in = comp_begin_ff;
         end else begin
            push     = 1'b1;
            depth_in = depth_ff + DW'(1);
            top_in   = comp_begin_ff;
         end
         comp_begin_in = canon_len_in;
      end

      // Read cursor
      if (is_read && rd_hit) begin
         read_pos_in = read_pos_ff + LW'(1);
      end

      // A start item clears the query
      if (is_start) begin
         canon_len_in  = '0;
         raw_len_in    = '0;
         depth_in      = '0;
         comp_begin_in = '0;
         dot_in        = DOT_EMPTY;
         rel_seen_in   = 1'b0;
         read_pos_in   = '0;
         ovf_in        = 1'b0;
      end
   end

   // Read item: length and flags of the result byte
   always_comb begin
      if (rel_seen_ff) begin
         rd_len = (comp_begin_ff == '0) ? LW'(1) : comp_begin_ff;
      end else begin
         rd_len = raw_len_ff;
      end
      rd_hit       = (read_pos_ff < rd_len);
      rsp_valid_in = is_read;
      rsp_empty_in = !rd_hit;
      rsp_last_in  = rd_hit && ((read_pos_ff + LW'(1)) == rd_len);
      rsp_ovf_in   = ovf_ff;
      rsp_slash_in = rel_seen_ff && (comp_begin_ff == '0);
      rsp_canon_in = rel_seen_ff;
      rsp_bank_in  = read_pos_ff[0];
   end

   // Canonical store writes: a new component writes '/' and the byte to
   // neighboring positions, which land in different banks.
   assign canon_wr  = ok && !is_slash;
   assign canon_new = at_begin;
   assign pos0      = canon_len_ff;
   assign pos1      = canon_len_ff + LW'(1);
   assign byte0     = canon_new ? CHAR_SLASH : req_ch;

   always_comb begin
      if (pos0[0]) begin
         odd_we     = canon_wr;
         odd_waddr  = CB_AW'(pos0 >> 1);
         odd_wdata  = byte0;
         even_we    = canon_wr && canon_new;
         even_waddr = CB_AW'(pos1 >> 1);
         even_wdata = req_ch;
      end else begin
         even_we    = canon_wr;
         even_waddr = CB_AW'(pos0 >> 1);
         even_wdata = byte0;
         odd_we     = canon_wr && canon_new;
         odd_waddr  = CB_AW'(pos1 >> 1);
         odd_wdata  = req_ch;
      end
   end

   assign canon_raddr = CB_AW'(read_pos_ff >> 1);

   pc_ram #(.WIDTH(8), .DEPTH(CB_DEPTH)) u_canon_even (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_waddr),
      .wr_data (even_wdata),
      .rd_addr (canon_raddr),
      .rd_data (even_rdata)
   );

   pc_ram #(.WIDTH(8), .DEPTH(CB_DEPTH)) u_canon_odd (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_waddr),
      .wr_data (odd_wdata),
      .rd_addr (canon_raddr),
      .rd_data (odd_rdata)
   );

   pc_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_raw (
      .clock   (clock),
      .wr_en   (ok && is_base),
      .wr_addr (RAW_AW'(raw_len_ff)),
      .wr_data (req_ch),
      .rd_addr (RAW_AW'(read_pos_ff)),
      .rd_data (raw_rdata)
   );

   // Component stack: top kept in top_ff, the entry below it is read ahead
   // from the next depth so a pop has it ready the following cycle.
   assign depth_less2 = depth_in - DW'(2);
   assign stack_raddr = SAW'(depth_less2);

   pc_ram #(.WIDTH(LW), .DEPTH(MAX_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (SAW'(depth_ff)),
      .wr_data (comp_begin_ff),
      .rd_addr (stack_raddr),
      .rd_data (under)
   );

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canon_len_ff  <= '0;
         raw_len_ff    <= '0;
         comp_begin_ff <= '0;
         read_pos_ff   <= '0;
         depth_ff      <= '0;
         dot_ff        <= DOT_EMPTY;
         rel_seen_ff   <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         canon_len_ff  <= canon_len_in;
         raw_len_ff    <= raw_len_in;
         comp_begin_ff <= comp_begin_in;
         read_pos_ff   <= read_pos_in;
         depth_ff      <= depth_in;
         dot_ff        <= dot_in;
         rel_seen_ff   <= rel_seen_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      top_ff       <= top_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_slash_ff <= rsp_slash_in;
      rsp_canon_ff <= rsp_canon_in;
      rsp_bank_ff  <= rsp_bank_in;
   end

   // Result byte selection after the registered store read
   always_comb begin
      priority if (rsp_empty_ff) begin
         rsp_out_char = CHAR_NUL;
      end else if (rsp_slash_ff) begin
         rsp_out_char = CHAR_SLASH;
      end else if (rsp_canon_ff) begin
         rsp_out_char = rsp_bank_ff ? odd_rdata : even_rdata;
      end else begin
         rsp_out_char = raw_rdata;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_out_empty    = rsp_empty_ff;
   assign rsp_out_overflow = rsp_ovf_ff;

   // Checks
   a_begin_le_len: assert property (@(posedge clock) disable iff (reset)
      comp_begin_ff <= canon_len_ff)
      else $error("component start beyond canonical length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (canon_len_ff <= LW'(PATH_BYTES)) && (raw_len_ff <= LW'(PATH_BYTES)))
      else $error("store length beyond capacity");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_DEPTH))
      else $error("stack depth beyond capacity");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      is_read |=> rsp_valid)
      else $error("read item without result");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      !is_read |=> !rsp_valid)
      else $error("result without read item");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(ovf_ff) |-> ($past(is_start) || $past(reset)))
      else $error("overflow flag cleared outside a start item");

endmodule
